// ===== hw/rtl/cicr_pkg.sv =====
// ----------------------------------------------------------------------------
// cicr_pkg
// Shared types, constants and fixed-point helpers for the circle collision
// resolver.
// ----------------------------------------------------------------------------
package cicr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int unsigned ONE = 1 << FRAC_BITS;
    localparam logic [16:0] CORR_RESET = 17'd13107;
    localparam logic signed [63:0] TRUNC_ADJ = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    typedef struct packed {
        logic [63:0] pos_a;
        logic [63:0] vel_a;
        logic [31:0] mass_a;
        logic [30:0] radius_a;
        logic [16:0] restitution_a;
        logic [63:0] pos_b;
        logic [63:0] vel_b;
        logic [31:0] mass_b;
        logic [30:0] radius_b;
        logic [16:0] restitution_b;
        logic        same_body;
    } in_word_t;

    typedef struct packed {
        logic [63:0]        new_pos_a;
        logic [63:0]        new_vel_a;
        logic [63:0]        new_pos_b;
        logic [63:0]        new_vel_b;
        logic               resolved;
        logic signed [31:0] overlap_depth;
    } out_word_t;

    // shift right by the fraction bits, rounding toward zero
    function automatic logic signed [63:0] tshift(input logic signed [63:0] v);
        logic signed [63:0] adj;
        adj = v + (v[63] ? TRUNC_ADJ : 64'sd0);
        return adj >>> FRAC_BITS;
    endfunction

    function automatic logic signed [39:0] mulq(input logic signed [39:0] a,
                                                input logic signed [18:0] b);
        logic signed [58:0] p;
        logic signed [63:0] t;
        p = 59'(a) * 59'(b);
        t = tshift(64'(p));
        return t[39:0];
    endfunction

    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -40'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== hw/rtl/circle_impulse_collision_resolver.sv =====
// ----------------------------------------------------------------------------
// circle_impulse_collision_resolver
// Impulse and positional correction for one pair of 2D circles per word.
// ----------------------------------------------------------------------------
// Takes one body pair per cycle while the skid word is free; most of the
// pipeline is the bit-per-stage square root (32 stages) feeding the
// bit-per-stage divide for the unit normal (17 stages). Mass weights are
// divided in parallel with the root. The result leaves through an output
// register backed by a one-word skid buffer, so input keeps flowing while a
// result waits; the pipeline freezes only while the skid word is occupied.
// The user writes correction_percent through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
module circle_impulse_collision_resolver (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cicr_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cicr_pkg::out_word_t  m_data,
    input  logic                 cfg_wr_en,
    input  logic [16:0]          cfg_wr_data
);
    import cicr_pkg::*;

    localparam int SQ_ITERS   = 32;
    localparam int W_BITS     = FRAC_BITS;
    localparam int NQ_BITS    = FRAC_BITS + 1;
    localparam int ST_SQ      = 1;
    localparam int ST_SUM     = 2;
    localparam int ST_RT0     = 3;
    localparam int ST_DIST    = ST_RT0 + SQ_ITERS;
    localparam int ST_DV0     = ST_DIST + 1;
    localparam int ST_NRM     = ST_DV0 + NQ_BITS;
    localparam int ST_PV      = ST_NRM + 1;
    localparam int ST_VN      = ST_PV + 1;
    localparam int ST_K       = ST_VN + 1;
    localparam int ST_KW      = ST_K + 1;
    localparam int ST_KN      = ST_KW + 1;
    localparam int ST_OUT     = ST_KN + 1;
    localparam int N_STAGES   = ST_OUT + 1;
    localparam int WREM_BITS  = 32 + FRAC_BITS + 1;
    localparam int NREM_BITS  = 33 + FRAC_BITS + 1;

    typedef struct packed {
        logic                   same;
        logic [63:0]            pa;
        logic [63:0]            va;
        logic [63:0]            pb;
        logic [63:0]            vb;
        logic signed [32:0]     dvx;
        logic signed [32:0]     dvy;
        logic                   dxn;
        logic                   dyn;
        logic [32:0]            mdx;
        logic [32:0]            mdy;
        logic [31:0]            ux;
        logic [31:0]            uy;
        logic                   sh;
        logic [32:0]            rsum;
        logic [17:0]            ope;
        logic [32:0]            msum;
        logic [WREM_BITS-1:0]   wra;
        logic [WREM_BITS-1:0]   wrb;
        logic [W_BITS-1:0]      wa;
        logic [W_BITS-1:0]      wb;
        logic [63:0]            sqx;
        logic [63:0]            sqy;
        logic [63:0]            rn;
        logic [63:0]            root;
        logic [32:0]            cdist;
        logic signed [34:0]     depth;
        logic                   act;
        logic                   bigx;
        logic                   bigy;
        logic [NREM_BITS-1:0]   nrx;
        logic [NREM_BITS-1:0]   nry;
        logic [NQ_BITS-1:0]     qx;
        logic [NQ_BITS-1:0]     qy;
        logic signed [17:0]     nx;
        logic signed [17:0]     ny;
        logic signed [50:0]     pvx;
        logic signed [50:0]     pvy;
        logic signed [39:0]     vn;
        logic signed [39:0]     k;
        logic signed [39:0]     c;
        logic signed [39:0]     ka;
        logic signed [39:0]     kb;
        logic signed [39:0]     ca;
        logic signed [39:0]     cb;
        logic signed [39:0]     dvax;
        logic signed [39:0]     dvay;
        logic signed [39:0]     dvbx;
        logic signed [39:0]     dvby;
        logic signed [39:0]     dpax;
        logic signed [39:0]     dpay;
        logic signed [39:0]     dpbx;
        logic signed [39:0]     dpby;
        out_word_t              res;
    } stage_t;

    function automatic stage_t stage_in(input in_word_t d);
        stage_t r;
        logic signed [32:0] dx, dy;
        logic [31:0] ma, mb;
        logic [16:0] e;
        r = '0;
        r.same = d.same_body;
        r.pa = d.pos_a;
        r.va = d.vel_a;
        r.pb = d.pos_b;
        r.vb = d.vel_b;
        dx = 33'(signed'(d.pos_b[63:32])) - 33'(signed'(d.pos_a[63:32]));
        dy = 33'(signed'(d.pos_b[31:0])) - 33'(signed'(d.pos_a[31:0]));
        r.dvx = 33'(signed'(d.vel_b[63:32])) - 33'(signed'(d.vel_a[63:32]));
        r.dvy = 33'(signed'(d.vel_b[31:0])) - 33'(signed'(d.vel_a[31:0]));
        r.dxn = dx[32];
        r.dyn = dy[32];
        r.mdx = dx[32] ? 33'(-dx) : 33'(dx);
        r.mdy = dy[32] ? 33'(-dy) : 33'(dy);
        // halve both offsets when either reaches 2^31 so the squares fit
        r.sh = r.mdx[32] | r.mdx[31] | r.mdy[32] | r.mdy[31];
        r.ux = r.sh ? r.mdx[32:1] : r.mdx[31:0];
        r.uy = r.sh ? r.mdy[32:1] : r.mdy[31:0];
        r.rsum = 33'(d.radius_a) + 33'(d.radius_b);
        e = (d.restitution_a < d.restitution_b) ? d.restitution_a : d.restitution_b;
        if (e > 17'(ONE)) begin
            e = 17'(ONE);
        end
        r.ope = 18'(ONE) + 18'(e);
        ma = (d.mass_a == 32'd0) ? 32'd1 : d.mass_a;
        mb = (d.mass_b == 32'd0) ? 32'd1 : d.mass_b;
        r.msum = 33'(ma) + 33'(mb);
        r.wra = WREM_BITS'(mb) << FRAC_BITS;
        r.wrb = WREM_BITS'(ma) << FRAC_BITS;
        return r;
    endfunction

    function automatic stage_t stage_fn(input int k, input stage_t s, input logic [16:0] corr);
        stage_t r;
        int i;
        int j;
        logic [63:0] bit_v;
        logic [WREM_BITS-1:0] wd;
        logic [NREM_BITS-1:0] nd;
        logic [NQ_BITS-1:0] q;
        logic signed [51:0] sum;
        logic signed [63:0] t;
        r = s;
        if (k == ST_SQ) begin
            r.sqx = 64'(s.ux) * 64'(s.ux);
            r.sqy = 64'(s.uy) * 64'(s.uy);
        end
        if (k == ST_SUM) begin
            r.rn = s.sqx + s.sqy;
            r.root = '0;
        end
        if (k >= ST_RT0 && k < ST_DIST) begin
            i = k - ST_RT0;
            bit_v = 64'd1 << (62 - 2 * i);
            if (s.rn >= s.root + bit_v) begin
                r.rn = s.rn - (s.root + bit_v);
                r.root = (s.root >> 1) + bit_v;
            end else begin
                r.root = s.root >> 1;
            end
        end
        // mass weights, restoring divide one quotient bit a stage
        if (k >= ST_RT0 && k < ST_RT0 + W_BITS) begin
            j = W_BITS - 1 - (k - ST_RT0);
            wd = WREM_BITS'(s.msum) << j;
            if (s.wra >= wd) begin
                r.wra = s.wra - wd;
                r.wa[j] = 1'b1;
            end
            if (s.wrb >= wd) begin
                r.wrb = s.wrb - wd;
                r.wb[j] = 1'b1;
            end
        end
        if (k == ST_DIST) begin
            r.cdist = 33'(s.root[31:0]) << s.sh;
            r.depth = signed'(35'(r.cdist)) - signed'(35'(s.rsum));
            r.act = !s.same && (r.cdist != 33'd0) && r.depth[34];
            r.bigx = {1'b0, s.mdx} >= {r.cdist, 1'b0};
            r.bigy = {1'b0, s.mdy} >= {r.cdist, 1'b0};
            r.nrx = NREM_BITS'(s.mdx) << FRAC_BITS;
            r.nry = NREM_BITS'(s.mdy) << FRAC_BITS;
        end
        if (k >= ST_DV0 && k < ST_NRM) begin
            j = NQ_BITS - 1 - (k - ST_DV0);
            nd = NREM_BITS'(s.cdist) << j;
            if (s.nrx >= nd) begin
                r.nrx = s.nrx - nd;
                r.qx[j] = 1'b1;
            end
            if (s.nry >= nd) begin
                r.nry = s.nry - nd;
                r.qy[j] = 1'b1;
            end
        end
        if (k == ST_NRM) begin
            q = (s.bigx || s.qx > NQ_BITS'(ONE)) ? NQ_BITS'(ONE) : s.qx;
            r.nx = s.dxn ? -signed'(18'(q)) : signed'(18'(q));
            q = (s.bigy || s.qy > NQ_BITS'(ONE)) ? NQ_BITS'(ONE) : s.qy;
            r.ny = s.dyn ? -signed'(18'(q)) : signed'(18'(q));
        end
        if (k == ST_PV) begin
            r.pvx = 51'(s.dvx) * 51'(s.nx);
            r.pvy = 51'(s.dvy) * 51'(s.ny);
        end
        if (k == ST_VN) begin
            sum = 52'(s.pvx) + 52'(s.pvy);
            t = tshift(64'(sum));
            r.vn = t[39:0];
        end
        if (k == ST_K) begin
            r.k = mulq(s.vn, signed'({1'b0, s.ope}));
            r.c = mulq(40'(s.depth), signed'({2'b0, corr}));
        end
        if (k == ST_KW) begin
            r.ka = mulq(s.k, signed'(19'(s.wa)));
            r.kb = mulq(s.k, signed'(19'(s.wb)));
            r.ca = mulq(s.c, signed'(19'(s.wa)));
            r.cb = mulq(s.c, signed'(19'(s.wb)));
        end
        if (k == ST_KN) begin
            r.dvax = mulq(s.ka, 19'(s.nx));
            r.dvay = mulq(s.ka, 19'(s.ny));
            r.dvbx = mulq(s.kb, 19'(s.nx));
            r.dvby = mulq(s.kb, 19'(s.ny));
            r.dpax = mulq(s.ca, 19'(s.nx));
            r.dpay = mulq(s.ca, 19'(s.ny));
            r.dpbx = mulq(s.cb, 19'(s.nx));
            r.dpby = mulq(s.cb, 19'(s.ny));
        end
        if (k == ST_OUT) begin
            r.res.resolved = s.act && s.vn[39];
            r.res.overlap_depth = s.same ? 32'sd0 : signed'(sat32(40'(s.depth)));
            if (r.res.resolved) begin
                r.res.new_pos_a = {sat32(40'(signed'(s.pa[63:32])) + s.dpax),
                                   sat32(40'(signed'(s.pa[31:0])) + s.dpay)};
                r.res.new_vel_a = {sat32(40'(signed'(s.va[63:32])) + s.dvax),
                                   sat32(40'(signed'(s.va[31:0])) + s.dvay)};
                r.res.new_pos_b = {sat32(40'(signed'(s.pb[63:32])) - s.dpbx),
                                   sat32(40'(signed'(s.pb[31:0])) - s.dpby)};
                r.res.new_vel_b = {sat32(40'(signed'(s.vb[63:32])) - s.dvbx),
                                   sat32(40'(signed'(s.vb[31:0])) - s.dvby)};
            end else begin
                r.res.new_pos_a = s.pa;
                r.res.new_vel_a = s.va;
                r.res.new_pos_b = s.pb;
                r.res.new_vel_b = s.vb;
            end
        end
        return r;
    endfunction

    logic [16:0]          corr_pct_reg;
    stage_t               stage_reg  [N_STAGES];
    stage_t               stage_next [N_STAGES];
    logic [N_STAGES-1:0]  vld_reg;
    out_word_t            out_reg, out_next, skid_reg, skid_next;
    logic                 out_vld_reg, out_vld_next, skid_vld_reg, skid_vld_next;
    logic                 en;

    // pipeline moves whenever the skid word is free
    assign en      = !skid_vld_reg;
    assign s_ready = en;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corr_pct_reg <= CORR_RESET;
        end else if (cfg_wr_en) begin
            corr_pct_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        stage_next[0] = stage_in(s_data);
        for (int k = 1; k < N_STAGES; k++) begin
            stage_next[k] = stage_fn(k, stage_reg[k-1], corr_pct_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N_STAGES-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    always_comb begin
        out_next      = out_reg;
        out_vld_next  = out_vld_reg;
        skid_next     = skid_reg;
        skid_vld_next = skid_vld_reg;
        if (skid_vld_reg) begin
            if (m_ready) begin
                out_next      = skid_reg;
                skid_vld_next = 1'b0;
            end
        end else if (vld_reg[N_STAGES-1]) begin
            if (!out_vld_reg || m_ready) begin
                out_next     = stage_reg[N_STAGES-1].res;
                out_vld_next = 1'b1;
            end else begin
                skid_next     = stage_reg[N_STAGES-1].res;
                skid_vld_next = 1'b1;
            end
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== hw/rtl/cicr_checker.sv =====
// ----------------------------------------------------------------------------
// cicr_checker
// Port-level checks for the circle collision resolver, bound to the top.
// ----------------------------------------------------------------------------
module cicr_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  cicr_pkg::out_word_t  m_data
);
    import cicr_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // with no result pending the skid word must be free
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_resolved_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.resolved |-> m_data.overlap_depth[31])
        else $error("resolved pair without overlap");

endmodule

bind circle_impulse_collision_resolver cicr_checker u_cicr_checker (.*);

// ===== tb/sv/circle_impulse_collision_resolver_checker.sv =====
// ----------------------------------------------------------------------------
// circle_impulse_collision_resolver_checker
// Watches both channels of the resolver, computes each pair's collision
// response in fixed point and compares it with the returned word.
// ----------------------------------------------------------------------------
module circle_impulse_collision_resolver_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  cicr_pkg::in_word_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  cicr_pkg::out_word_t m_data,
    input  logic                cfg_wr_en,
    input  logic [16:0]         cfg_wr_data,
    output int                  errors,
    output int                  pending
);
    import cicr_pkg::*;

    localparam int FB = 16;
    localparam longint QONE = 64'sd1 << FB;

    logic [16:0] corr_pct;
    out_word_t   resp_q[$];

    function automatic longint sx(input logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint trunc_fb(input longint v);
        longint m;
        m = (v < 0) ? -v : v;
        m = m >>> FB;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return trunc_fb(a * b);
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unit_comp(input longint d, input logic [63:0] cdist);
        logic [63:0] q, m;
        m = (d < 0) ? -d : d;
        q = (m << FB) / cdist;
        if (q > QONE) q = QONE;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic out_word_t resolve_pair(input in_word_t w, input logic [16:0] pct);
        out_word_t   r;
        longint      pax, pay, vax, vay, pbx, pby, vbx, vby, dx, dy, depth;
        longint      nx, ny, vn, k, ka, kb, c, ca, cb;
        logic [63:0] ux, uy, cdist, ma, mb, e, wa, wb;
        bit          sh, hit;
        pax = sx(w.pos_a[63:32]); pay = sx(w.pos_a[31:0]);
        vax = sx(w.vel_a[63:32]); vay = sx(w.vel_a[31:0]);
        pbx = sx(w.pos_b[63:32]); pby = sx(w.pos_b[31:0]);
        vbx = sx(w.vel_b[63:32]); vby = sx(w.vel_b[31:0]);
        depth = 0;
        hit = 0;
        if (!w.same_body) begin
            dx = pbx - pax;
            dy = pby - pay;
            ux = (dx < 0) ? -dx : dx;
            uy = (dy < 0) ? -dy : dy;
            sh = (ux >= 64'h8000_0000) || (uy >= 64'h8000_0000);
            if (sh) begin
                ux = ux >> 1;
                uy = uy >> 1;
            end
            cdist = root64(ux * ux + uy * uy) << sh;
            depth = longint'(cdist) - (longint'(w.radius_a) + longint'(w.radius_b));
            if (cdist != 0 && depth < 0) begin
                nx = unit_comp(dx, cdist);
                ny = unit_comp(dy, cdist);
                vn = trunc_fb((vbx - vax) * nx + (vby - vay) * ny);
                if (vn < 0) begin
                    e = (w.restitution_a < w.restitution_b) ? w.restitution_a
                                                            : w.restitution_b;
                    if (e > QONE) e = QONE;
                    ma = (w.mass_a == 0) ? 1 : w.mass_a;
                    mb = (w.mass_b == 0) ? 1 : w.mass_b;
                    wa = (mb << FB) / (ma + mb);
                    wb = (ma << FB) / (ma + mb);
                    k  = qmul(QONE + longint'(e), vn);
                    ka = qmul(k, longint'(wa));
                    kb = qmul(k, longint'(wb));
                    vax += qmul(ka, nx); vay += qmul(ka, ny);
                    vbx -= qmul(kb, nx); vby -= qmul(kb, ny);
                    c  = qmul(depth, longint'(pct));
                    ca = qmul(c, longint'(wa));
                    cb = qmul(c, longint'(wb));
                    pax += qmul(ca, nx); pay += qmul(ca, ny);
                    pbx -= qmul(cb, nx); pby -= qmul(cb, ny);
                    hit = 1;
                end
            end
        end
        r.new_pos_a     = {clamp32(pax), clamp32(pay)};
        r.new_vel_a     = {clamp32(vax), clamp32(vay)};
        r.new_pos_b     = {clamp32(pbx), clamp32(pby)};
        r.new_vel_b     = {clamp32(vbx), clamp32(vby)};
        r.resolved      = hit;
        r.overlap_depth = clamp32(depth);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            corr_pct = CORR_RESET;
            resp_q.delete();
            errors = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (resp_q.size() == 0) begin
                    report_mismatch("unexpected word", m_data.new_pos_a, 64'd0);
                end else begin
                    want = resp_q.pop_front();
                    if (m_data.new_pos_a !== want.new_pos_a)
                        report_mismatch("new_pos_a", m_data.new_pos_a, want.new_pos_a);
                    if (m_data.new_vel_a !== want.new_vel_a)
                        report_mismatch("new_vel_a", m_data.new_vel_a, want.new_vel_a);
                    if (m_data.new_pos_b !== want.new_pos_b)
                        report_mismatch("new_pos_b", m_data.new_pos_b, want.new_pos_b);
                    if (m_data.new_vel_b !== want.new_vel_b)
                        report_mismatch("new_vel_b", m_data.new_vel_b, want.new_vel_b);
                    if (m_data.resolved !== want.resolved)
                        report_mismatch("resolved", 64'(m_data.resolved),
                                        64'(want.resolved));
                    if (m_data.overlap_depth !== want.overlap_depth)
                        report_mismatch("overlap_depth", 64'(m_data.overlap_depth),
                                        64'(want.overlap_depth));
                end
            end
            if (s_valid && s_ready) resp_q.push_back(resolve_pair(s_data, corr_pct));
            if (cfg_wr_en) corr_pct = cfg_wr_data;
        end
        pending = resp_q.size();
    end
endmodule

// ===== tb/sv/circle_impulse_collision_resolver_tb.sv =====
// ----------------------------------------------------------------------------
// circle_impulse_collision_resolver_tb
// Drives directed and random circle pairs with random stalls on both sides,
// across several correction settings; the checker scores every result.
// ----------------------------------------------------------------------------
module circle_impulse_collision_resolver_tb;
    import cicr_pkg::*;

    localparam int LATENCY   = 60;
    localparam int WDOG_MAX  = 2000;
    localparam int N_RANDOM  = 1600;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    in_word_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    out_word_t   m_data;
    logic        cfg_wr_en = 0;
    logic [16:0] cfg_wr_data = '0;
    int          errors, pending;
    int          idle_cycles = 0;
    bit          calm = 0;

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    circle_impulse_collision_resolver dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    circle_impulse_collision_resolver_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .errors(errors), .pending(pending)
    );

    // receiver stalls in bursts
    always @(posedge aclk) begin
        int n;
        if (calm || $urandom_range(0, 3) != 0) begin
            m_ready <= 1;
        end else begin
            n = $urandom_range(1, 13);
            m_ready <= 0;
            repeat (n) @(posedge aclk);
            m_ready <= 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("circle_impulse_collision_resolver: mismatch");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord(input int span);
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    // mostly nearby, often overlapping pairs; the rest anything the fields allow
    function automatic in_word_t rand_pair();
        in_word_t w;
        int span;
        logic [31:0] ax, ay;
        span = $urandom_range(1, 4) * 65536 * $urandom_range(1, 8);
        w = $bits(in_word_t)'({$urandom(), $urandom(), $urandom(), $urandom(),
                               $urandom(), $urandom(), $urandom(), $urandom(),
                               $urandom(), $urandom(), $urandom(), $urandom(),
                               $urandom(), $urandom()});
        if ($urandom_range(0, 9) < 8) begin
            ax = $urandom();
            ay = $urandom();
            w.pos_a = {ax, ay};
            w.pos_b = {ax + 32'($signed($urandom_range(0, 2 * span)) - span),
                       ay + 32'($signed($urandom_range(0, 2 * span)) - span)};
            w.vel_a = {rand_coord(span), rand_coord(span)};
            w.vel_b = {rand_coord(span), rand_coord(span)};
            w.radius_a = ($urandom_range(0, 9) == 0) ? 31'($urandom())
                                                     : 31'($urandom_range(0, span));
            w.radius_b = ($urandom_range(0, 9) == 0) ? 31'($urandom())
                                                     : 31'($urandom_range(0, span));
            w.mass_a = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 1 << 22);
            w.mass_b = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 1 << 22);
            w.restitution_a = ($urandom_range(0, 9) == 0) ? 17'($urandom())
                                                          : 17'($urandom_range(0, ONE));
            w.restitution_b = ($urandom_range(0, 9) == 0) ? 17'($urandom())
                                                          : 17'($urandom_range(0, ONE));
            w.same_body = ($urandom_range(0, 19) == 0);
        end
        return w;
    endfunction

    task automatic send_word(input in_word_t w);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 13);
            s_valid <= 0;
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic write_pct(input logic [16:0] v);
        cfg_wr_en   <= 1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
        @(posedge aclk);
    endtask

    // head-on collision along x, body B centered 'gap' away from A
    function automatic in_word_t head_on(input logic [31:0] gap, input logic [31:0] va);
        in_word_t w;
        w = '0;
        w.pos_a = {32'h0001_0000, 32'h0002_0000};
        w.pos_b = {32'h0001_0000 + gap, 32'h0002_0000};
        w.vel_a = {va, 32'h0};
        w.vel_b = {-va, 32'h0000_8000};
        w.mass_a = 32'h0001_0000;
        w.mass_b = 32'h0003_0000;
        w.radius_a = 31'h0001_0000;
        w.radius_b = 31'h0001_0000;
        w.restitution_a = 17'h0_8000;
        w.restitution_b = 17'h1_0000;
        return w;
    endfunction

    initial begin
        in_word_t w;
        logic [16:0] pcts[4];
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: collision, separating, apart, touching, same body, zero distance
        send_word(head_on(32'h0001_0000, 32'h0002_0000));
        send_word(head_on(32'h0001_0000, 32'hfffe_0000));
        send_word(head_on(32'h0005_0000, 32'h0002_0000));
        send_word(head_on(32'h0002_0000, 32'h0002_0000));
        w = head_on(32'h0001_0000, 32'h0002_0000); w.same_body = 1; send_word(w);
        w = head_on(32'h0, 32'h0002_0000); send_word(w);
        w.radius_a = '1; w.radius_b = '1; send_word(w);
        w = head_on(32'h0001_0000, 32'h7fff_ffff); w.mass_a = 0; w.mass_b = 0; send_word(w);
        w = head_on(32'h0000_0001, 32'h8000_0000); w.mass_a = '1; w.mass_b = 1;
        w.restitution_a = '1; w.restitution_b = '1; send_word(w);
        w = head_on(32'h0001_0000, 32'h0002_0000); w.restitution_a = 0; send_word(w);
        w = '1; w.same_body = 0; send_word(w);
        w = '0; w.pos_a = {32'h8000_0000, 32'h8000_0000};
        w.pos_b = {32'h7fff_ffff, 32'h7fff_ffff}; w.radius_a = '1; w.radius_b = '1;
        w.vel_a = {32'h7fff_ffff, 32'h7fff_ffff}; w.vel_b = {32'h8000_0000, 32'h8000_0000};
        send_word(w);
        w.pos_b = {32'h8000_0000, 32'h7fff_ffff}; send_word(w);
        drain();

        pcts = '{17'd0, 17'h1_0000, 17'h1_ffff, 17'd13107};
        for (int p = 0; p < 4; p++) begin
            write_pct(pcts[p]);
            for (int i = 0; i < N_RANDOM / 4; i++) begin
                if (p == 3 && i > N_RANDOM / 8) calm = 1;
                send_word(rand_pair());
            end
            drain();
        end

        if (errors == 0) begin
            $display("circle_impulse_collision_resolver: match");
        end else begin
            $display("circle_impulse_collision_resolver: mismatch");
        end
        $finish;
    end
endmodule
